FILE: hw/rtl/mer_pkg.sv
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer package
// Control word layout, field codes and the microprogram ROM of the sequencer.
// ----------------------------------------------------------------------------
package mer_pkg;

    localparam int ADDR_W    = 6;
    localparam int AXIS_W    = 10;
    localparam int SQ_W      = 20;
    localparam int MULB_W    = 12;
    localparam int PROD_W    = 32;
    localparam int COORD_W   = 11;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEMI_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEMI_Y = 2'd1;

    // drawing phase
    localparam logic [1:0] PH_A    = 2'd0;
    localparam logic [1:0] PH_B    = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;

    // multiplier operand A
    localparam logic [1:0] MA_A  = 2'd0;
    localparam logic [1:0] MA_B  = 2'd1;
    localparam logic [1:0] MA_AA = 2'd2;
    localparam logic [1:0] MA_BB = 2'd3;

    // multiplier operand B
    localparam logic [2:0] MB_A   = 3'd0;
    localparam logic [2:0] MB_B   = 3'd1;
    localparam logic [2:0] MB_X   = 3'd2;
    localparam logic [2:0] MB_Y   = 3'd3;
    localparam logic [2:0] MB_X1D = 3'd4;
    localparam logic [2:0] MB_Y1D = 3'd5;

    // square register write
    localparam logic [1:0] SQ_NONE = 2'd0;
    localparam logic [1:0] SQ_AA   = 2'd1;
    localparam logic [1:0] SQ_BB   = 2'd2;

    // accumulator operation
    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_ADD  = 2'd1;
    localparam logic [1:0] ACC_LOAD = 2'd2;
    localparam logic [1:0] ACC_DIV4 = 2'd3;

    // accumulator term source
    localparam logic [1:0] SRC_AA = 2'd0;
    localparam logic [1:0] SRC_BB = 2'd1;
    localparam logic [1:0] SRC_P  = 2'd2;

    // coordinate update
    localparam logic [2:0] XY_HOLD = 3'd0;
    localparam logic [2:0] XY_INC  = 3'd1;
    localparam logic [2:0] XY_DEC  = 3'd2;
    localparam logic [2:0] XY_AXIS = 3'd3;
    localparam logic [2:0] XY_ZERO = 3'd4;

    // emitted quadrant
    localparam logic [1:0] PT_PP = 2'd0;
    localparam logic [1:0] PT_NP = 2'd1;
    localparam logic [1:0] PT_PN = 2'd2;
    localparam logic [1:0] PT_NN = 2'd3;

    // jump condition
    localparam logic [2:0] CND_NONE    = 3'd0;
    localparam logic [2:0] CND_ALWAYS  = 3'd1;
    localparam logic [2:0] CND_NOT_A   = 3'd2;
    localparam logic [2:0] CND_NOT_B   = 3'd3;
    localparam logic [2:0] CND_Q_GE_P  = 3'd4;
    localparam logic [2:0] CND_Q_LE_P  = 3'd5;
    localparam logic [2:0] CND_NOT_NEG = 3'd6;

    // program labels
    localparam logic [ADDR_W-1:0] L_RESTART = 6'd0;
    localparam logic [ADDR_W-1:0] L_ADVANCE = 6'd7;
    localparam logic [ADDR_W-1:0] L_A_POS   = 6'd15;
    localparam logic [ADDR_W-1:0] L_A_END   = 6'd18;
    localparam logic [ADDR_W-1:0] L_B_CHK   = 6'd23;
    localparam logic [ADDR_W-1:0] L_B_POS   = 6'd27;
    localparam logic [ADDR_W-1:0] L_EMIT4   = 6'd30;
    localparam logic [ADDR_W-1:0] L_B_END   = 6'd34;
    localparam logic [ADDR_W-1:0] L_DONE    = 6'd35;

    typedef struct packed {
        logic [1:0]        ma;
        logic [2:0]        mb;
        logic              mul_en;
        logic              mul_q;
        logic [1:0]        sq_wr;
        logic [1:0]        acc_op;
        logic [1:0]        acc_src;
        logic [1:0]        acc_sh;
        logic              acc_neg;
        logic [2:0]        x_op;
        logic [2:0]        y_op;
        logic              ph_wr;
        logic [1:0]        ph_val;
        logic              emit;
        logic [1:0]        pt;
        logic              last;
        logic              done;
        logic [2:0]        cnd;
        logic [ADDR_W-1:0] target;
        logic              fin;
    } ctrl_t;

    function automatic ctrl_t ucode(input logic [ADDR_W-1:0] addr);
        ctrl_t w;
        w = '0;
        unique case (addr)
            // restart: squares, region A start decision, point (0,b)
            6'd0:
            begin
                w.ma = MA_A; w.mb = MB_A; w.mul_en = 1'b1;
            end
            6'd1:
            begin
                w.sq_wr = SQ_AA; w.ma = MA_B; w.mb = MB_B; w.mul_en = 1'b1;
            end
            6'd2:
            begin
                w.sq_wr = SQ_BB; w.ma = MA_AA; w.mb = MB_B; w.mul_en = 1'b1;
                w.acc_op = ACC_LOAD; w.acc_src = SRC_AA;
            end
            6'd3:
            begin
                w.acc_op = ACC_ADD; w.acc_src = SRC_BB; w.acc_sh = 2'd2;
            end
            6'd4:
            begin
                w.acc_op = ACC_ADD; w.acc_src = SRC_P; w.acc_sh = 2'd2; w.acc_neg = 1'b1;
            end
            6'd5:
            begin
                w.acc_op = ACC_DIV4; w.x_op = XY_ZERO; w.y_op = XY_AXIS;
                w.ph_wr = 1'b1; w.ph_val = PH_A;
            end
            6'd6:
            begin
                w.emit = 1'b1; w.pt = PT_PP; w.last = 1'b1; w.fin = 1'b1;
            end
            // advance: squares, then q = bb*x and p = aa*y for the slope test
            6'd7:
            begin
                w.ma = MA_A; w.mb = MB_A; w.mul_en = 1'b1;
            end
            6'd8:
            begin
                w.sq_wr = SQ_AA; w.ma = MA_B; w.mb = MB_B; w.mul_en = 1'b1;
            end
            6'd9:
            begin
                w.sq_wr = SQ_BB; w.ma = MA_AA; w.mb = MB_Y; w.mul_en = 1'b1;
            end
            6'd10:
            begin
                w.ma = MA_BB; w.mb = MB_X; w.mul_en = 1'b1; w.mul_q = 1'b1;
            end
            6'd11:
            begin
                w.cnd = CND_NOT_A; w.target = L_B_CHK;
            end
            // region A step
            6'd12:
            begin
                w.cnd = CND_Q_GE_P; w.target = L_A_END;
            end
            6'd13:
            begin
                w.ma = MA_BB; w.mb = MB_X1D; w.mul_en = 1'b1; w.x_op = XY_INC;
                w.cnd = CND_NOT_NEG; w.target = L_A_POS;
            end
            6'd14:
            begin
                w.acc_op = ACC_ADD; w.acc_src = SRC_P;
                w.cnd = CND_ALWAYS; w.target = L_EMIT4;
            end
            6'd15:
            begin
                w.acc_op = ACC_ADD; w.acc_src = SRC_P; w.y_op = XY_DEC;
            end
            6'd16:
            begin
                w.ma = MA_AA; w.mb = MB_Y; w.mul_en = 1'b1;
            end
            6'd17:
            begin
                w.acc_op = ACC_ADD; w.acc_src = SRC_P; w.acc_sh = 2'd1; w.acc_neg = 1'b1;
                w.cnd = CND_ALWAYS; w.target = L_EMIT4;
            end
            // region A finished: region B start decision, point (a,0)
            6'd18:
            begin
                w.ma = MA_BB; w.mb = MB_A; w.mul_en = 1'b1;
                w.acc_op = ACC_LOAD; w.acc_src = SRC_BB;
            end
            6'd19:
            begin
                w.acc_op = ACC_ADD; w.acc_src = SRC_AA; w.acc_sh = 2'd2;
            end
            6'd20:
            begin
                w.acc_op = ACC_ADD; w.acc_src = SRC_P; w.acc_sh = 2'd2; w.acc_neg = 1'b1;
            end
            6'd21:
            begin
                w.acc_op = ACC_DIV4; w.x_op = XY_AXIS; w.y_op = XY_ZERO;
                w.ph_wr = 1'b1; w.ph_val = PH_B;
            end
            6'd22:
            begin
                w.emit = 1'b1; w.pt = PT_PP; w.last = 1'b1; w.fin = 1'b1;
            end
            // region B step
            6'd23:
            begin
                w.cnd = CND_NOT_B; w.target = L_DONE;
            end
            6'd24:
            begin
                w.cnd = CND_Q_LE_P; w.target = L_B_END;
            end
            6'd25:
            begin
                w.ma = MA_AA; w.mb = MB_Y1D; w.mul_en = 1'b1; w.y_op = XY_INC;
                w.cnd = CND_NOT_NEG; w.target = L_B_POS;
            end
            6'd26:
            begin
                w.acc_op = ACC_ADD; w.acc_src = SRC_P;
                w.cnd = CND_ALWAYS; w.target = L_EMIT4;
            end
            6'd27:
            begin
                w.acc_op = ACC_ADD; w.acc_src = SRC_P; w.x_op = XY_DEC;
            end
            6'd28:
            begin
                w.ma = MA_BB; w.mb = MB_X; w.mul_en = 1'b1;
            end
            6'd29:
            begin
                w.acc_op = ACC_ADD; w.acc_src = SRC_P; w.acc_sh = 2'd1; w.acc_neg = 1'b1;
            end
            // four mirrored points
            6'd30:
            begin
                w.emit = 1'b1; w.pt = PT_PP;
            end
            6'd31:
            begin
                w.emit = 1'b1; w.pt = PT_NP;
            end
            6'd32:
            begin
                w.emit = 1'b1; w.pt = PT_PN;
            end
            6'd33:
            begin
                w.emit = 1'b1; w.pt = PT_NN; w.last = 1'b1; w.fin = 1'b1;
            end
            6'd34:
            begin
                w.ph_wr = 1'b1; w.ph_val = PH_DONE;
            end
            6'd35:
            begin
                w.emit = 1'b1; w.done = 1'b1; w.last = 1'b1; w.fin = 1'b1;
            end
            default:
            begin
                w.fin = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

FILE: hw/rtl/midpoint_ellipse_rasterizer.sv
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer
// Microcoded sequencer over one shared multiplier and a decision accumulator.
// ----------------------------------------------------------------------------
// A restart transfer loads region A at (0,b) and returns that point. An
// advance transfer runs one midpoint step: the four mirrored points come out
// one per cycle while the output is not stalled; a region change returns its
// single start point and a finished drawing its done result. A stalled output
// holds the sequencer at its next emitting step. The microprogram uses the
// single 20x12 multiplier several times per step (squares, slope test products
// and decision terms), and the output register holds one point at a time. One
// item is in work at a time; in_stall is high from the input transfer until
// the last result is loaded.
module midpoint_ellipse_rasterizer #(
    parameter int DECISION_BITS = 48
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 restart,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mer_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mer_pkg::AXIS_W-1:0]           cfg_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [mer_pkg::COORD_W-1:0]   px,
    output logic signed [mer_pkg::COORD_W-1:0]   py,
    output logic                                 region,
    output logic                                 done_res,
    output logic                                 last
);

    localparam int DB = DECISION_BITS;

    logic [mer_pkg::AXIS_W-1:0]  semi_x_reg, semi_x_next;
    logic [mer_pkg::AXIS_W-1:0]  semi_y_reg, semi_y_next;
    logic [mer_pkg::AXIS_W-1:0]  x_reg, x_next;
    logic [mer_pkg::AXIS_W-1:0]  y_reg, y_next;
    logic [DB-1:0]               acc_reg, acc_next;
    logic [1:0]                  phase_reg, phase_next;
    logic                        busy_reg, busy_next;
    logic [mer_pkg::ADDR_W-1:0]  pc_reg, pc_next;
    logic                        out_valid_reg, out_valid_next;

    logic [mer_pkg::SQ_W-1:0]    aa_reg, aa_next;
    logic [mer_pkg::SQ_W-1:0]    bb_reg, bb_next;
    logic [mer_pkg::PROD_W-1:0]  p_reg, p_next;
    logic [mer_pkg::PROD_W-1:0]  q_reg, q_next;
    logic [mer_pkg::COORD_W-1:0] px_reg, px_next;
    logic [mer_pkg::COORD_W-1:0] py_reg, py_next;
    logic                        region_reg, region_next;
    logic                        done_reg, done_next;
    logic                        last_reg, last_next;

    mer_pkg::ctrl_t              cw;
    logic                        step_go;
    logic                        taken;
    logic [mer_pkg::SQ_W-1:0]    mul_a;
    logic [mer_pkg::MULB_W-1:0]  mul_b;
    logic [mer_pkg::PROD_W-1:0]  prod;
    logic [mer_pkg::PROD_W-1:0]  src_val;
    logic [DB-1:0]               term_sh;
    logic [DB-1:0]               term;
    logic [DB-1:0]               acc_adj;
    logic [mer_pkg::COORD_W-1:0] xw, yw;

    assign cw        = mer_pkg::ucode(pc_reg);
    assign in_stall  = busy_reg;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign px        = px_reg;
    assign py        = py_reg;
    assign region    = region_reg;
    assign done_res  = done_reg;
    assign last      = last_reg;

    // an emitting step waits for the output register to free up
    assign step_go = busy_reg && (!cw.emit || !out_valid_reg || !out_stall);

    always_comb
    begin
        unique case (cw.cnd)
            mer_pkg::CND_NONE:    taken = 1'b0;
            mer_pkg::CND_ALWAYS:  taken = 1'b1;
            mer_pkg::CND_NOT_A:   taken = (phase_reg != mer_pkg::PH_A);
            mer_pkg::CND_NOT_B:   taken = (phase_reg != mer_pkg::PH_B);
            mer_pkg::CND_Q_GE_P:  taken = (q_reg >= p_reg);
            mer_pkg::CND_Q_LE_P:  taken = (q_reg <= p_reg);
            mer_pkg::CND_NOT_NEG: taken = !acc_reg[DB-1];
            default:              taken = 1'b0;
        endcase
    end

    // shared multiplier
    always_comb
    begin
        unique case (cw.ma)
            mer_pkg::MA_A:  mul_a = {10'd0, semi_x_reg};
            mer_pkg::MA_B:  mul_a = {10'd0, semi_y_reg};
            mer_pkg::MA_AA: mul_a = aa_reg;
            mer_pkg::MA_BB: mul_a = bb_reg;
            default:        mul_a = aa_reg;
        endcase
        unique case (cw.mb)
            mer_pkg::MB_A:   mul_b = {2'd0, semi_x_reg};
            mer_pkg::MB_B:   mul_b = {2'd0, semi_y_reg};
            mer_pkg::MB_X:   mul_b = {2'd0, x_reg};
            mer_pkg::MB_Y:   mul_b = {2'd0, y_reg};
            mer_pkg::MB_X1D: mul_b = {1'b0, x_reg, 1'b1} + 12'd2;
            mer_pkg::MB_Y1D: mul_b = {1'b0, y_reg, 1'b1} + 12'd2;
            default:         mul_b = '0;
        endcase
        prod = {12'd0, mul_a} * {20'd0, mul_b};
    end

    // accumulator term: source scaled by 1, 2 or 4, optionally negated
    always_comb
    begin
        unique case (cw.acc_src)
            mer_pkg::SRC_AA: src_val = {12'd0, aa_reg};
            mer_pkg::SRC_BB: src_val = {12'd0, bb_reg};
            mer_pkg::SRC_P:  src_val = p_reg;
            default:         src_val = p_reg;
        endcase
        term_sh = DB'(src_val) << cw.acc_sh;
        term    = cw.acc_neg ? (DB'(0) - term_sh) : term_sh;
        // divide by 4 truncating toward zero: bias negative values by 3
        acc_adj = acc_reg + (acc_reg[DB-1] ? {{(DB-2){1'b0}}, 2'b11} : DB'(0));
    end

    always_comb
    begin
        semi_x_next    = semi_x_reg;
        semi_y_next    = semi_y_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        acc_next       = acc_reg;
        phase_next     = phase_reg;
        busy_next      = busy_reg;
        pc_next        = pc_reg;
        out_valid_next = out_valid_reg;
        aa_next        = aa_reg;
        bb_next        = bb_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        region_next    = region_reg;
        done_next      = done_reg;
        last_next      = last_reg;
        xw             = {1'b0, x_reg};
        yw             = {1'b0, y_reg};

        if (cfg_valid)
        begin
            unique case (cfg_index)
                mer_pkg::CFG_SEMI_X: semi_x_next = cfg_data;
                mer_pkg::CFG_SEMI_Y: semi_y_next = cfg_data;
                default:
                begin
                end
            endcase
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (!busy_reg)
        begin
            if (in_valid)
            begin
                busy_next = 1'b1;
                pc_next   = restart ? mer_pkg::L_RESTART : mer_pkg::L_ADVANCE;
            end
        end
        else if (step_go)
        begin
            pc_next = taken ? cw.target : pc_reg + 1'b1;
            if (cw.fin)
            begin
                busy_next = 1'b0;
            end

            if (cw.mul_en)
            begin
                if (cw.mul_q)
                    q_next = prod;
                else
                    p_next = prod;
            end

            unique case (cw.sq_wr)
                mer_pkg::SQ_AA: aa_next = p_reg[mer_pkg::SQ_W-1:0];
                mer_pkg::SQ_BB: bb_next = p_reg[mer_pkg::SQ_W-1:0];
                default:
                begin
                end
            endcase

            unique case (cw.acc_op)
                mer_pkg::ACC_ADD:  acc_next = acc_reg + term;
                mer_pkg::ACC_LOAD: acc_next = term;
                mer_pkg::ACC_DIV4: acc_next = {{2{acc_adj[DB-1]}}, acc_adj[DB-1:2]};
                default:
                begin
                end
            endcase

            case (cw.x_op)
                mer_pkg::XY_INC:  x_next = x_reg + 1'b1;
                mer_pkg::XY_DEC:  x_next = x_reg - 1'b1;
                mer_pkg::XY_AXIS: x_next = semi_x_reg;
                mer_pkg::XY_ZERO: x_next = '0;
                default:
                begin
                end
            endcase

            case (cw.y_op)
                mer_pkg::XY_INC:  y_next = y_reg + 1'b1;
                mer_pkg::XY_DEC:  y_next = y_reg - 1'b1;
                mer_pkg::XY_AXIS: y_next = semi_y_reg;
                mer_pkg::XY_ZERO: y_next = '0;
                default:
                begin
                end
            endcase

            if (cw.ph_wr)
            begin
                phase_next = cw.ph_val;
            end

            if (cw.emit)
            begin
                out_valid_next = 1'b1;
                last_next      = cw.last;
                done_next      = cw.done;
                if (cw.done)
                begin
                    px_next     = '0;
                    py_next     = '0;
                    region_next = 1'b0;
                end
                else
                begin
                    region_next = (phase_reg == mer_pkg::PH_B);
                    unique case (cw.pt)
                        mer_pkg::PT_PP:
                        begin
                            px_next = xw;
                            py_next = yw;
                        end
                        mer_pkg::PT_NP:
                        begin
                            px_next = 11'd0 - xw;
                            py_next = yw;
                        end
                        mer_pkg::PT_PN:
                        begin
                            px_next = xw;
                            py_next = 11'd0 - yw;
                        end
                        default:
                        begin
                            px_next = 11'd0 - xw;
                            py_next = 11'd0 - yw;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            semi_x_reg    <= 10'd80;
            semi_y_reg    <= 10'd50;
            x_reg         <= '0;
            y_reg         <= '0;
            acc_reg       <= '0;
            phase_reg     <= mer_pkg::PH_DONE;
            busy_reg      <= 1'b0;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            semi_x_reg    <= semi_x_next;
            semi_y_reg    <= semi_y_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            acc_reg       <= acc_next;
            phase_reg     <= phase_next;
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        aa_reg     <= aa_next;
        bb_reg     <= bb_next;
        p_reg      <= p_next;
        q_reg      <= q_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        region_reg <= region_next;
        done_reg   <= done_next;
        last_reg   <= last_next;
    end

endmodule

FILE: hw/rtl/mer_checker.sv
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer checker
// Port-level properties of the rasterizer, attached by bind.
// ----------------------------------------------------------------------------
module mer_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_stall,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic signed [mer_pkg::COORD_W-1:0] px,
    input logic signed [mer_pkg::COORD_W-1:0] py,
    input logic                               region,
    input logic                               done_res,
    input logic                               last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(px) && $stable(py)
            && $stable(region) && $stable(done_res) && $stable(last))
        else $error("stalled result changed");

    // no item follows in the cycle after an input transfer
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted back to back");

    // the next mirrored point is loaded as soon as a non-last one is taken
    a_burst_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid)
        else $error("gap inside a point burst");

    // a done result carries no point and closes its item
    a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> last && px == 0 && py == 0 && !region)
        else $error("malformed done result");

endmodule

bind midpoint_ellipse_rasterizer mer_checker u_mer_checker (.*);

FILE: test/midpoint_ellipse_rasterizer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer testbench
// Sends restart and advance transfers, writes the semi-axis registers between
// phases, traces the expected arc with an integer midpoint tracer and checks
// every plotted point against it in order, under random idling and stalls.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_tb;

    localparam int DEC_W = 48;

    // restart field codes
    localparam bit OP_ADVANCE = 1'b0;
    localparam bit OP_RESTART = 1'b1;

    // indexes with no register behind them
    localparam logic [mer_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [mer_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic [mer_pkg::COORD_W-1:0] px;
        logic [mer_pkg::COORD_W-1:0] py;
        logic                        region;
        logic                        done_res;
        logic                        last;
    } point_t;

    logic                               clk       = 1'b0;
    logic                               rst_n     = 1'b0;
    logic                               in_valid  = 1'b0;
    logic                               in_stall;
    logic                               restart   = 1'b0;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [mer_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [mer_pkg::AXIS_W-1:0]         cfg_data  = '0;
    logic                               out_valid;
    logic                               out_stall = 1'b0;
    logic signed [mer_pkg::COORD_W-1:0] px;
    logic signed [mer_pkg::COORD_W-1:0] py;
    logic                               region;
    logic                               done_res;
    logic                               last;

    // tracer state, mirrors the block after reset
    logic [mer_pkg::AXIS_W-1:0] axis_a      = 10'd80;
    logic [mer_pkg::AXIS_W-1:0] axis_b      = 10'd50;
    logic [mer_pkg::AXIS_W-1:0] trace_x     = '0;
    logic [mer_pkg::AXIS_W-1:0] trace_y     = '0;
    logic [DEC_W-1:0]           trace_dec   = '0;
    logic [1:0]                 trace_phase = mer_pkg::PH_DONE;

    point_t expected_points[$];
    int     errors     = 0;
    int     items_sent = 0;
    bit     sender_idles    = 1'b1;
    bit     receiver_stalls = 1'b1;

    midpoint_ellipse_rasterizer #(
        .DECISION_BITS(DEC_W)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .restart  (restart),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .px       (px),
        .py       (py),
        .region   (region),
        .done_res (done_res),
        .last     (last)
    );

    always #6 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void push_point(input longint x, input longint y, input logic reg_b,
                                       input logic fin_draw, input logic fin_item);
        point_t p;
        p.px       = x[mer_pkg::COORD_W-1:0];
        p.py       = y[mer_pkg::COORD_W-1:0];
        p.region   = reg_b;
        p.done_res = fin_draw;
        p.last     = fin_item;
        expected_points.push_back(p);
    endfunction

    function automatic void push_mirrored(input logic reg_b);
        longint x;
        longint y;
        x = longint'(trace_x);
        y = longint'(trace_y);
        push_point(x, y, reg_b, 1'b0, 1'b0);
        push_point(-x, y, reg_b, 1'b0, 1'b0);
        push_point(x, -y, reg_b, 1'b0, 1'b0);
        push_point(-x, -y, reg_b, 1'b0, 1'b1);
    endfunction

    // one midpoint step of the arc tracer
    function automatic void trace_step(input bit rs);
        longint a;
        longint b;
        longint aa;
        longint bb;
        longint x;
        longint y;
        longint init;
        longint delta;
        a  = longint'(axis_a);
        b  = longint'(axis_b);
        aa = a * a;
        bb = b * b;
        x  = longint'(trace_x);
        y  = longint'(trace_y);
        if (rs == OP_RESTART)
        begin
            init        = (4 * bb + aa * (1 - 4 * b)) / 4;
            trace_x     = '0;
            trace_y     = axis_b;
            trace_dec   = init[DEC_W-1:0];
            trace_phase = mer_pkg::PH_A;
            push_point(0, b, 1'b0, 1'b0, 1'b1);
        end
        else if (trace_phase == mer_pkg::PH_A && bb * x < aa * y)
        begin
            x = x + 1;
            if (trace_dec[DEC_W-1])
                delta = bb * (2 * x + 1);
            else
            begin
                y     = y - 1;
                delta = bb * (2 * x + 1) - 2 * aa * y;
            end
            trace_dec = trace_dec + delta[DEC_W-1:0];
            trace_x   = x[mer_pkg::AXIS_W-1:0];
            trace_y   = y[mer_pkg::AXIS_W-1:0];
            push_mirrored(1'b0);
        end
        else if (trace_phase == mer_pkg::PH_A)
        begin
            init        = (4 * aa + bb * (1 - 4 * a)) / 4;
            trace_x     = axis_a;
            trace_y     = '0;
            trace_dec   = init[DEC_W-1:0];
            trace_phase = mer_pkg::PH_B;
            push_point(a, 0, 1'b1, 1'b0, 1'b1);
        end
        else if (trace_phase == mer_pkg::PH_B && bb * x > aa * y)
        begin
            y = y + 1;
            if (trace_dec[DEC_W-1])
                delta = aa * (2 * y + 1);
            else
            begin
                x     = x - 1;
                delta = -2 * bb * x + aa * (2 * y + 1);
            end
            trace_dec = trace_dec + delta[DEC_W-1:0];
            trace_x   = x[mer_pkg::AXIS_W-1:0];
            trace_y   = y[mer_pkg::AXIS_W-1:0];
            push_mirrored(1'b1);
        end
        else
        begin
            if (trace_phase == mer_pkg::PH_B)
                trace_phase = mer_pkg::PH_DONE;
            push_point(0, 0, 1'b0, 1'b1, 1'b1);
        end
    endfunction

    // valid stays high after the transfer so back-to-back items need no toggle
    task automatic send_item(input bit rs);
        while (sender_idles && $urandom_range(99) < 6)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        restart  <= rs;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        trace_step(rs);
        items_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_axis(input logic [mer_pkg::CFG_IDX_W-1:0] idx,
                              input logic [mer_pkg::AXIS_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == mer_pkg::CFG_SEMI_X)
            axis_a = val;
        else if (idx == mer_pkg::CFG_SEMI_Y)
            axis_b = val;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_axes(input logic [mer_pkg::AXIS_W-1:0] a,
                            input logic [mer_pkg::AXIS_W-1:0] b);
        drain_results();
        write_axis(mer_pkg::CFG_SEMI_X, a);
        write_axis(mer_pkg::CFG_SEMI_Y, b);
    endtask

    task automatic draw_from_top(input int advances);
        send_item(OP_RESTART);
        repeat (advances) send_item(OP_ADVANCE);
    endtask

    task automatic test_after_reset();
        send_item(OP_ADVANCE);
        send_item(OP_ADVANCE);
        draw_from_top(3);
    endtask

    task automatic test_axis_extremes();
        set_axes(10'd1, 10'd1);
        draw_from_top(6);
        // strongly negative start decision, truncated toward zero
        set_axes(10'd1023, 10'd1);
        draw_from_top(2);
        set_axes(10'd1023, 10'd1023);
        draw_from_top(1);
        // zero axes: both regions end at once
        set_axes(10'd0, 10'd0);
        draw_from_top(2);
    endtask

    task automatic test_spare_registers();
        drain_results();
        write_axis(CFG_SPARE_LO, 10'h3FF);
        write_axis(CFG_SPARE_HI, 10'h155);
        draw_from_top(1);
    endtask

    task automatic test_back_to_back();
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
        set_axes(10'd20, 10'd12);
        draw_from_top(36);
        drain_results();
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
    endtask

    task automatic test_sender_pause();
        set_axes(10'd9, 10'd5);
        draw_from_top(5);
        drain_results();
        repeat (10) send_item(OP_ADVANCE);
    endtask

    task automatic test_random_drawings();
        int unsigned                pick;
        int unsigned                steps;
        logic [mer_pkg::AXIS_W-1:0] a;
        logic [mer_pkg::AXIS_W-1:0] b;
        while (items_sent < 160)
        begin
            pick = $urandom_range(9);
            if (pick == 7)
            begin
                a     = mer_pkg::AXIS_W'($urandom_range(1023));
                b     = mer_pkg::AXIS_W'($urandom_range(1023));
                steps = 5;
            end
            else
            begin
                a     = mer_pkg::AXIS_W'($urandom_range(1, 12));
                b     = mer_pkg::AXIS_W'($urandom_range(1, 12));
                steps = 32'(a) + 32'(b) + 32'd4;
            end
            set_axes(a, b);
            // an axis change without restart keeps tracing with the new values
            if (pick < 8)
                send_item(OP_RESTART);
            if (pick == 9)
                repeat (8) send_item($urandom_range(9) < 3);
            else
                repeat (steps) send_item($urandom_range(99) < 3);
        end
    endtask

    always @(posedge clk)
        out_stall <= receiver_stalls && ($urandom_range(99) < 6);

    always @(posedge clk)
    begin
        point_t seen;
        point_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            seen = {px, py, region, done_res, last};
            if (expected_points.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected point px=%0d py=%0d region=%0d done=%0d last=%0d",
                         $time, px, py, region, done_res, last);
            end
            else
            begin
                want = expected_points.pop_front();
                if (seen !== want)
                begin
                    errors++;
                    $display({"%0t: expected px=%0d py=%0d region=%0d done=%0d last=%0d,",
                              " got px=%0d py=%0d region=%0d done=%0d last=%0d"},
                             $time, $signed(want.px), $signed(want.py), want.region,
                             want.done_res, want.last, px, py, region, done_res, last);
                end
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_after_reset();
        test_axis_extremes();
        test_spare_registers();
        test_back_to_back();
        test_sender_pause();
        test_random_drawings();
        drain_results();
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
